/* design/bmftl_pkg.sv */
// Shared constants and word types for the block-mapped flash translation layer.
package bmftl_pkg;

	localparam int DATA_BLOCKS     = 16;
	localparam int BLOCK_PAGES     = 8;
	localparam int BUF_PAGES       = 4;
	localparam int NONBUF_PAGES    = BLOCK_PAGES - BUF_PAGES;
	localparam int TOTAL_BLOCKS    = DATA_BLOCKS + 1;
	localparam int TOTAL_PAGES     = TOTAL_BLOCKS * BLOCK_PAGES;

	localparam int LSN_W   = 6;
	localparam int ADDR_W  = 8;
	localparam int TAG_W   = 7;
	localparam int PBN_W   = 5;
	localparam int LBN_W   = 4;
	localparam int OFF_W   = 2;
	localparam int BIDX_W  = 2;
	localparam int PAGE_W  = 3;
	localparam int PIDX_W  = $clog2(TOTAL_PAGES);

	localparam logic [TAG_W-1:0] EMPTY_TAG = 7'h40;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_PROGRAM = 2'd1;
	localparam logic [1:0] CMD_ERASE   = 2'd2;

	localparam logic SRC_HOST = 1'b0;
	localparam logic SRC_COPY = 1'b1;

	typedef struct packed {
		logic             op;
		logic [LSN_W-1:0] lsn;
	} req_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] address;
		logic              source;
		logic [LSN_W-1:0]  spare_tag;
		logic              last;
	} rsp_t;

endpackage

/* design/block_mapped_ftl_with_log_pages.sv */
// One request at a time: busy is high until the last command is issued.
// The page tag memory has registered read data, so each tag lookup takes a read state and a compare state.
// Reset clears all page tags at once through per-page valid flags and restores the map.
// Each command word shows for one cycle on strobe; the receiver cannot stall.
module block_mapped_ftl_with_log_pages (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bmftl_pkg::req_t req,
	output logic            busy,
	output logic            strobe,
	output bmftl_pkg::rsp_t result
);
	import bmftl_pkg::*;

	localparam logic [3:0] S_IDLE        = 4'd0;
	localparam logic [3:0] S_SCAN_RD     = 4'd1;
	localparam logic [3:0] S_SCAN_CMP    = 4'd2;
	localparam logic [3:0] S_RD_EMIT     = 4'd3;
	localparam logic [3:0] S_W_RD        = 4'd4;
	localparam logic [3:0] S_W_CHK       = 4'd5;
	localparam logic [3:0] S_W_PROG      = 4'd6;
	localparam logic [3:0] S_BUF_DONE    = 4'd7;
	localparam logic [3:0] S_MERGE_FIRST = 4'd8;
	localparam logic [3:0] S_MERGE_RD    = 4'd9;
	localparam logic [3:0] S_MERGE_CHK   = 4'd10;
	localparam logic [3:0] S_MERGE_CPRD  = 4'd11;
	localparam logic [3:0] S_MERGE_CPPG  = 4'd12;
	localparam logic [3:0] S_ERASE       = 4'd13;

	localparam logic [BIDX_W-1:0] BIDX_LAST = BIDX_W'(BUF_PAGES - 1);
	localparam logic [OFF_W:0]    I_END     = (OFF_W+1)'(NONBUF_PAGES);

	logic [3:0]       state_q, ret_q;
	logic [LSN_W-1:0] lsn_q;
	logic [PBN_W-1:0] pbn_q, spare_q;
	logic [PBN_W-1:0] map_q [DATA_BLOCKS];
	logic [TAG_W-1:0] key_q;
	logic [BIDX_W-1:0] idx_q;
	logic             up_q, found_q;
	logic [OFF_W:0]   i_q;
	logic [TOTAL_PAGES-1:0] valid_q;
	logic             rvalid_q;
	logic             strobe_q;
	rsp_t             result_q;

	logic [PIDX_W-1:0] raddr, waddr;
	logic [TAG_W-1:0]  wdata, rdata, tag_rd;
	logic              we;
	logic [OFF_W-1:0]  off;
	logic [LBN_W-1:0]  lbn;

	assign off = lsn_q[OFF_W-1:0];
	assign lbn = lsn_q[LSN_W-1:OFF_W];
	assign tag_rd = rvalid_q ? rdata : EMPTY_TAG;

	// Tag memory address and write selection per state
	always_comb begin
		raddr = {pbn_q, 1'b1, idx_q};
		we    = 1'b0;
		waddr = {pbn_q, 1'b0, off};
		wdata = {1'b0, lsn_q};
		case (state_q)
			S_W_RD:     raddr = {pbn_q, 1'b0, off};
			S_MERGE_RD: raddr = {pbn_q, 1'b0, i_q[OFF_W-1:0]};
			S_W_CHK:    we = (tag_rd == EMPTY_TAG);
			S_BUF_DONE: begin
				we    = found_q;
				waddr = {pbn_q, 1'b1, idx_q};
			end
			S_MERGE_FIRST: begin
				we    = 1'b1;
				waddr = {spare_q, 1'b0, off};
			end
			S_MERGE_CPPG: begin
				we    = 1'b1;
				waddr = {spare_q, 1'b0, i_q[OFF_W-1:0]};
				wdata = key_q;
			end
			default: ;
		endcase
	end

	bmftl_ram #(.WIDTH(TAG_W), .DEPTH(TOTAL_PAGES)) u_tags (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		rvalid_q <= valid_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			valid_q  <= '0;
			spare_q  <= PBN_W'(DATA_BLOCKS);
			for (int k = 0; k < DATA_BLOCKS; k++) begin
				map_q[k] <= PBN_W'(k);
			end
			strobe_q <= 1'b0;
			lsn_q    <= '0;
			pbn_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
			up_q     <= 1'b0;
			found_q  <= 1'b0;
			i_q      <= '0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			result_q <= '0;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						lsn_q <= req.lsn;
						pbn_q <= map_q[req.lsn[LSN_W-1:OFF_W]];
						if (req.op == OP_READ) begin
							key_q <= {1'b0, req.lsn};
							idx_q <= BIDX_LAST;
							up_q  <= 1'b0;
							ret_q <= S_RD_EMIT;
							state_q <= S_SCAN_RD;
						end else begin
							state_q <= S_W_RD;
						end
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CMP;
				S_SCAN_CMP: begin
					if (tag_rd == key_q) begin
						found_q <= 1'b1;
						state_q <= ret_q;
					end else if ((up_q && idx_q == BIDX_LAST) ||
					             (!up_q && idx_q == '0)) begin
						found_q <= 1'b0;
						state_q <= ret_q;
					end else begin
						idx_q   <= up_q ? idx_q + 1'b1 : idx_q - 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_RD_EMIT: begin
					strobe_q           <= 1'b1;
					result_q.cmd       <= CMD_READ;
					result_q.address   <= found_q ? {pbn_q, 1'b1, idx_q} : {pbn_q, 1'b0, off};
					result_q.last      <= 1'b1;
					state_q            <= S_IDLE;
				end
				S_W_RD: state_q <= S_W_CHK;
				S_W_CHK: begin
					strobe_q         <= 1'b1;
					result_q.cmd     <= CMD_READ;
					result_q.address <= {pbn_q, 1'b0, off};
					if (tag_rd == EMPTY_TAG) begin
						state_q <= S_W_PROG;
					end else if (tag_rd == {1'b0, lsn_q}) begin
						key_q   <= EMPTY_TAG;
						idx_q   <= '0;
						up_q    <= 1'b1;
						ret_q   <= S_BUF_DONE;
						state_q <= S_SCAN_RD;
					end else begin
						// foreign sector in the data page: stop after the read
						result_q.last <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_W_PROG: begin
					strobe_q           <= 1'b1;
					result_q.cmd       <= CMD_PROGRAM;
					result_q.address   <= {pbn_q, 1'b0, off};
					result_q.source    <= SRC_HOST;
					result_q.spare_tag <= lsn_q;
					result_q.last      <= 1'b1;
					state_q            <= S_IDLE;
				end
				S_BUF_DONE: begin
					if (found_q) begin
						strobe_q           <= 1'b1;
						result_q.cmd       <= CMD_PROGRAM;
						result_q.address   <= {pbn_q, 1'b1, idx_q};
						result_q.source    <= SRC_HOST;
						result_q.spare_tag <= lsn_q;
						result_q.last      <= 1'b1;
						state_q            <= S_IDLE;
					end else begin
						state_q <= S_MERGE_FIRST;
					end
				end
				S_MERGE_FIRST: begin
					strobe_q           <= 1'b1;
					result_q.cmd       <= CMD_PROGRAM;
					result_q.address   <= {spare_q, 1'b0, off};
					result_q.source    <= SRC_HOST;
					result_q.spare_tag <= lsn_q;
					i_q                <= '0;
					state_q            <= S_MERGE_RD;
				end
				S_MERGE_RD: begin
					if (i_q == I_END) begin
						state_q <= S_ERASE;
					end else if (i_q[OFF_W-1:0] == off) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_MERGE_CHK;
					end
				end
				S_MERGE_CHK: begin
					if (tag_rd == EMPTY_TAG) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_MERGE_RD;
					end else begin
						key_q   <= tag_rd;
						idx_q   <= BIDX_LAST;
						up_q    <= 1'b0;
						ret_q   <= S_MERGE_CPRD;
						state_q <= S_SCAN_RD;
					end
				end
				S_MERGE_CPRD: begin
					strobe_q         <= 1'b1;
					result_q.cmd     <= CMD_READ;
					result_q.address <= found_q ? {pbn_q, 1'b1, idx_q}
					                            : {pbn_q, 1'b0, i_q[OFF_W-1:0]};
					state_q          <= S_MERGE_CPPG;
				end
				S_MERGE_CPPG: begin
					strobe_q           <= 1'b1;
					result_q.cmd       <= CMD_PROGRAM;
					result_q.address   <= {spare_q, 1'b0, i_q[OFF_W-1:0]};
					result_q.source    <= SRC_COPY;
					result_q.spare_tag <= key_q[LSN_W-1:0];
					i_q                <= i_q + 1'b1;
					state_q            <= S_MERGE_RD;
				end
				S_ERASE: begin
					strobe_q         <= 1'b1;
					result_q.cmd     <= CMD_ERASE;
					result_q.address <= ADDR_W'(pbn_q);
					result_q.last    <= 1'b1;
					// drop every tag of the erased block
					for (int k = 0; k < BLOCK_PAGES; k++) begin
						valid_q[{pbn_q, PAGE_W'(k)}] <= 1'b0;
					end
					map_q[lbn] <= spare_q;
					spare_q    <= pbn_q;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

`ifndef SYNTH
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last)
		else $error("request ended without a last command");
	a_erase_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.cmd == CMD_ERASE |-> result.last)
		else $error("erase not flagged last");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("last command while still busy");
	a_spare_range: assert property (@(posedge clk) disable iff (!arst_n)
		spare_q <= PBN_W'(DATA_BLOCKS))
		else $error("spare block out of range");
`endif
endmodule

/* design/bmftl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bmftl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
